@@ rtl/lfu_pkg.sv @@
// Package for the LFU cache with expiry: sizes, codes, controller states
// and the command/status structs between controller and datapath. No dependencies.
`default_nettype none
package lfu_pkg;
    localparam int CAPACITY       = 16;
    localparam int USE_COUNT_BITS = 16;
    localparam int SLOT_BITS      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_BITS       = $clog2(CAPACITY + 1);
    localparam int CAP_REG_BITS   = 5;
    localparam logic [CAP_REG_BITS-1:0] CAP_RESET = CAP_REG_BITS'(16);

    typedef logic [USE_COUNT_BITS-1:0] t_uses;
    typedef logic [SLOT_BITS-1:0]      t_slot;
    typedef logic [CNT_BITS-1:0]       t_count;

    typedef enum logic [1:0] {
        OP_GET  = 2'd0,
        OP_PUT  = 2'd1,
        OP_TICK = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_MISS     = 3'd0,
        ST_HIT      = 3'd1,
        ST_EXPIRED  = 3'd2,
        ST_UPDATED  = 3'd3,
        ST_INSERTED = 3'd4,
        ST_EVICTED  = 3'd5,
        ST_TICK     = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;   // capture input item, clear scan state
        logic scan;   // examine one slot
        logic decide; // apply the operation
    } t_cmd;

    typedef struct packed {
        logic scan_last;
    } t_stat;
endpackage
`default_nettype wire

@@ rtl/lfu_if.sv @@
// Valid/ready channel interfaces for the LFU cache with expiry.
// No dependencies.
`default_nettype none
interface lfu_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic signed [31:0] lookup_key;
    logic signed [31:0] store_value;
    logic [29:0] lifetime_ms;
    modport source (output valid, operation, lookup_key, store_value, lifetime_ms,
                    input ready);
    modport sink   (input valid, operation, lookup_key, store_value, lifetime_ms,
                    output ready);
endinterface

interface lfu_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic signed [31:0] read_value;
    logic signed [31:0] victim_key;
    modport source (output valid, status, read_value, victim_key, input ready);
    modport sink   (input valid, status, read_value, victim_key, output ready);
endinterface

interface lfu_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

@@ rtl/lfu_cache_with_expiry.sv @@
// Top level of the LFU cache with expiry: controller plus datapath.
// Depends on lfu_pkg, lfu_if, lfu_ctrl, lfu_dp.
//
//  channel | dir | fields
//  i_req   | in  | operation, lookup_key, store_value, lifetime_ms
//  o_rsp   | out | status, read_value, victim_key
//  i_cfg   | in  | data = active_capacity
//
// Each item passes through accept, a match/victim scan over every slot in turn,
// a decide step, then the result is held until taken.
// Synchronous active-low reset clears valid bits, clock, order counter; sets capacity to 16.
// A new item is accepted only after the previous result has been taken.
`default_nettype none
module lfu_cache_with_expiry (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lfu_req_if.sink   i_req,
    lfu_rsp_if.source o_rsp,
    lfu_cfg_if.sink   i_cfg
);
    import lfu_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign i_cfg.ready = 1'b1;

    lfu_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .o_out_valid(o_rsp.valid),
        .i_out_ready(o_rsp.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    lfu_dp u_dp (
        .i_clk, .i_rst_n,
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_operation  (i_req.operation),
        .i_lookup_key (i_req.lookup_key),
        .i_store_value(i_req.store_value),
        .i_lifetime_ms(i_req.lifetime_ms),
        .i_cfg_we     (i_cfg.valid),
        .i_cfg_data   (i_cfg.data),
        .o_status     (o_rsp.status),
        .o_read_value (o_rsp.read_value),
        .o_victim_key (o_rsp.victim_key)
    );
endmodule
`default_nettype wire

@@ rtl/lfu_ctrl.sv @@
// Controller FSM for the LFU cache: sequences load, slot scan, decide, output.
// Depends on lfu_pkg.
`default_nettype none
module lfu_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    input  lfu_pkg::t_stat     i_stat,
    output lfu_pkg::t_cmd      o_cmd
);
    import lfu_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_SCAN;
            S_SCAN:   if (i_stat.scan_last) n_state = S_DECIDE;
            S_DECIDE: n_state = S_OUT;
            S_OUT:    if (i_out_ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = (r_state == S_IDLE);
        o_out_valid = (r_state == S_OUT);
        o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.scan   = (r_state == S_SCAN);
        o_cmd.decide = (r_state == S_DECIDE);
    end

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("ready and valid together");
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.scan) else $error("scan did not follow load");
    a_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.decide |=> o_out_valid) else $error("result not shown after decide");
endmodule
`default_nettype wire

@@ rtl/lfu_dp.sv @@
// Datapath for the LFU cache: slot store, one-slot-per-cycle scan for key match,
// victim and free slot, and the update/insert/evict logic. Depends on lfu_pkg.
`default_nettype none
module lfu_dp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  lfu_pkg::t_cmd      i_cmd,
    output lfu_pkg::t_stat     o_stat,
    input  wire logic [1:0]    i_operation,
    input  wire logic [31:0]   i_lookup_key,
    input  wire logic [31:0]   i_store_value,
    input  wire logic [29:0]   i_lifetime_ms,
    input  wire logic          i_cfg_we,
    input  wire logic [4:0]    i_cfg_data,
    output logic [2:0]         o_status,
    output logic [31:0]        o_read_value,
    output logic [31:0]        o_victim_key
);
    import lfu_pkg::*;

    logic [CAPACITY-1:0] r_valid;
    logic [31:0] r_key   [CAPACITY];
    logic [31:0] r_value [CAPACITY];
    t_uses       r_uses  [CAPACITY];
    logic [31:0] r_dl    [CAPACITY];
    logic [31:0] r_stamp [CAPACITY];
    logic [31:0] r_clock, r_order;
    logic [CAP_REG_BITS-1:0] r_cap;

    logic [1:0]  r_op;
    logic [31:0] r_ikey, r_ival;
    logic [29:0] r_life;
    t_slot  r_idx;
    logic   r_hit_f;  t_slot r_hit;
    logic   r_free_f; t_slot r_free;
    logic   r_vic_f;  t_slot r_vic;
    t_uses  r_vic_uses;
    logic [31:0] r_vic_age;
    t_count r_cnt;
    logic [2:0]  r_status;
    logic [31:0] r_rval, r_vkey;
    logic [2:0]  n_status;
    logic [31:0] n_rval, n_vkey;

    logic [31:0] age;
    logic        better;
    assign age    = r_order - r_stamp[r_idx];
    assign better = !r_vic_f || (r_uses[r_idx] < r_vic_uses) ||
                    (r_uses[r_idx] == r_vic_uses && age > r_vic_age);
    assign o_stat.scan_last = (r_idx == t_slot'(CAPACITY - 1));

    // effective capacity clamp
    t_count eff_cap;
    always_comb begin
        if (r_cap == '0)
            eff_cap = t_count'(1);
        else if (32'(r_cap) > 32'(CAPACITY))
            eff_cap = t_count'(CAPACITY);
        else
            eff_cap = t_count'(r_cap);
    end

    logic [31:0] hit_diff;
    logic        hit_exp;
    logic        evict;
    t_slot       ins_slot;
    logic        ins_ok;
    assign hit_diff = r_clock - r_dl[r_hit];
    assign hit_exp  = hit_diff != '0 && !hit_diff[31];
    assign evict    = (r_cnt >= eff_cap) && r_vic_f;
    always_comb begin
        ins_slot = r_free;
        ins_ok   = r_free_f;
        if (evict && (!r_free_f || r_vic < r_free)) begin
            ins_slot = r_vic;
            ins_ok   = 1'b1;
        end
    end

    // result of the current transaction
    always_comb begin
        n_status = ST_MISS;
        n_rval   = '0;
        n_vkey   = '0;
        case (t_op'(r_op))
            OP_TICK: n_status = ST_TICK;
            OP_GET: begin
                if (r_hit_f) begin
                    if (hit_exp) begin
                        n_status = ST_EXPIRED;
                    end else begin
                        n_status = ST_HIT;
                        n_rval   = r_value[r_hit];
                    end
                end
            end
            OP_PUT: begin
                if (r_hit_f) begin
                    n_status = ST_UPDATED;
                end else begin
                    n_status = evict ? ST_EVICTED : ST_INSERTED;
                    if (evict) n_vkey = r_key[r_vic];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_clock <= '0;
            r_order <= '0;
            r_cap   <= CAP_RESET;
        end else begin
            if (i_cfg_we) r_cap <= i_cfg_data;
            if (i_cmd.decide) begin
                unique case (t_op'(r_op))
                    OP_TICK: r_clock <= r_clock + 32'd1;
                    OP_GET: begin
                        if (r_hit_f) begin
                            if (hit_exp) begin
                                r_valid[r_hit] <= 1'b0;
                            end else begin
                                r_order <= r_order + 32'd1;
                            end
                        end
                    end
                    OP_PUT: begin
                        r_order <= r_order + 32'd1;
                        if (!r_hit_f) begin
                            // victim slot reused in place stays valid
                            if (evict && ins_slot != r_vic) r_valid[r_vic] <= 1'b0;
                            if (ins_ok) r_valid[ins_slot] <= 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // payload, scan, result and slot store registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_operation; r_ikey <= i_lookup_key;
            r_ival <= i_store_value; r_life <= i_lifetime_ms;
            r_idx <= '0; r_hit_f <= 1'b0; r_free_f <= 1'b0; r_vic_f <= 1'b0;
            r_cnt <= '0; r_hit <= '0; r_free <= '0; r_vic <= '0;
        end
        if (i_cmd.scan) begin
            r_idx <= r_idx + t_slot'(1);
            if (!r_valid[r_idx]) begin
                if (!r_free_f) begin r_free_f <= 1'b1; r_free <= r_idx; end
            end else begin
                r_cnt <= r_cnt + t_count'(1);
                if (!r_hit_f && r_key[r_idx] == r_ikey) begin
                    r_hit_f <= 1'b1; r_hit <= r_idx;
                end
                if (better) begin
                    r_vic_f <= 1'b1; r_vic <= r_idx;
                    r_vic_uses <= r_uses[r_idx]; r_vic_age <= age;
                end
            end
        end
        if (i_cmd.decide) begin
            r_status <= n_status;
            r_rval   <= n_rval;
            r_vkey   <= n_vkey;
            unique case (t_op'(r_op))
                OP_TICK: ;
                OP_GET: begin
                    if (r_hit_f && !hit_exp) begin
                        if (r_uses[r_hit] != '1) r_uses[r_hit] <= r_uses[r_hit] + t_uses'(1);
                        r_stamp[r_hit] <= r_order;
                    end
                end
                OP_PUT: begin
                    if (r_hit_f) begin
                        if (r_uses[r_hit] != '1) r_uses[r_hit] <= r_uses[r_hit] + t_uses'(1);
                        r_stamp[r_hit] <= r_order;
                        r_value[r_hit] <= r_ival;
                        r_dl[r_hit]    <= r_clock + 32'(r_life);
                    end else if (ins_ok) begin
                        r_key[ins_slot]   <= r_ikey;
                        r_value[ins_slot] <= r_ival;
                        r_uses[ins_slot]  <= t_uses'(1);
                        r_dl[ins_slot]    <= r_clock + 32'(r_life);
                        r_stamp[ins_slot] <= r_order;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_status     = r_status;
    assign o_read_value = r_rval;
    assign o_victim_key = r_vkey;

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan |-> 32'(r_cnt) <= 32'(r_idx)) else $error("valid count ran ahead");
    a_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.decide && r_op == OP_TICK) |=> r_clock == $past(r_clock) + 32'd1)
        else $error("tick did not advance clock");
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.decide |=> $stable(r_order)) else $error("order counter moved outside decide");
endmodule
`default_nettype wire
